>>> sv/lpht_pkg.sv
package lpht_pkg;

  // Table geometry.
  localparam int TABLE_SIZE = 11;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE);

  // Field widths fixed by the interface.
  localparam int LEN_W = 4;
  localparam int KEY_W = 44;
  localparam int REC_W = 32;
  localparam int SLOT_W = 6;
  localparam int DIGITS = KEY_W / 4;

  // Key length limits.
  localparam int MIN_LEN = 2;
  localparam int MAX_LEN = 11;

  // Home slot hashing: (d0 * 10 + d1) mod 11 via a reciprocal multiply.
  localparam int DIGIT_BASE = 10;
  localparam int HOME_MOD = 11;
  localparam int HOME_RECIP = 93;
  localparam int RECIP_SHIFT = 10;

  typedef enum logic [2:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_DUPLICATE = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_FOUND     = 3'd3,
    STATUS_NOT_FOUND = 3'd4,
    STATUS_INVALID   = 3'd5
  } status_t;

  typedef enum logic {
    ACTION_INSERT = 1'b0,
    ACTION_SEARCH = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_t;

  typedef struct packed {
    action_t            action;
    logic [LEN_W-1:0]   key_length;
    logic [KEY_W-1:0]   key_digits;
    logic [REC_W-1:0]   record_word;
  } lpht_in_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot_index;
    logic [REC_W-1:0]   found_record;
  } lpht_out_t;

  // One slot as it sits in the memory.
  typedef struct packed {
    logic [LEN_W-1:0]   key_length;
    logic [KEY_W-1:0]   key_digits;
    logic [REC_W-1:0]   record_word;
  } lpht_entry_t;

  localparam int ENTRY_W = $bits(lpht_entry_t);

  // Home slot of a key from its first two decimal digits.
  function automatic logic [3:0] home_slot(input logic [3:0] d0, input logic [3:0] d1);
    logic [6:0]  v;
    logic [13:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    v = 7'(d0 * 7'(DIGIT_BASE)) + 7'(d1);
    p = 14'(v) * 14'(HOME_RECIP);
    q = p[RECIP_SHIFT +: 4];
    r = v - 7'(q * 7'(HOME_MOD));
    if (r >= 7'(HOME_MOD)) begin
      r = r - 7'(HOME_MOD);
    end
    return r[3:0];
  endfunction

endpackage

>>> sv/linear_probe_hash_table.sv
// Linear-probing hash table for phone-number keys of 2 to 11 BCD digits, with
// TABLE_SIZE slots that each hold a key and a 32-bit record word. An item is an
// insert or a search; every item gives exactly one result beat. A valid key is
// accepted, then probes 1 to TABLE_SIZE slots in turn through the single read
// port of the slot memory, which delivers one slot per cycle, and its result
// then moves to the output register; a rejected key goes from acceptance
// straight to the output register. The next item is taken while the previous
// result still waits on the output. All slots are empty after reset at once,
// tracked by one valid flop per slot, so no clearing pass is needed.
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  lpht_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lpht_out_t out_data
);

  state_t                state;
  state_t                state_next;
  lpht_in_t              cur;
  logic [IDX_W-1:0]      pos;
  logic [IDX_W-1:0]      next_pos;
  logic [CNT_W-1:0]      count;
  lpht_out_t             res;
  logic [TABLE_SIZE-1:0] valid;
  logic                  rd_valid;

  logic                  accept;
  logic                  key_ok;
  logic [KEY_W-1:0]      key_kept;
  logic [IDX_W-1:0]      home;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic                  out_load;
  logic                  probe_done;
  lpht_out_t             probe_res;
  logic [ENTRY_W-1:0]    rd_bits;
  lpht_entry_t           rd_entry;
  lpht_entry_t           wr_entry;

  assign accept = in_valid && !in_stall;

  // Key check, digit masking and home slot of the incoming item.
  always_comb begin
    logic [3:0] nib;
    key_ok = (in_data.key_length >= LEN_W'(MIN_LEN)) &&
             (in_data.key_length <= LEN_W'(MAX_LEN));
    key_kept = '0;
    for (int i = 0; i < DIGITS; i++) begin
      nib = in_data.key_digits[KEY_W-4-4*i +: 4];
      if (LEN_W'(i) < in_data.key_length) begin
        key_kept[KEY_W-4-4*i +: 4] = nib;
        if (nib > 4'd9) begin
          key_ok = 1'b0;
        end
      end
    end
    home = IDX_W'(home_slot(in_data.key_digits[KEY_W-1 -: 4],
                            in_data.key_digits[KEY_W-5 -: 4]));
  end

  // Probe step: decide on the slot whose data arrives this cycle.
  assign rd_entry = lpht_entry_t'(rd_bits);

  always_comb begin
    logic occupied;
    logic equal;
    occupied = rd_valid && (rd_entry.key_length != '0);
    equal = occupied && (rd_entry.key_length == cur.key_length) &&
            (rd_entry.key_digits == cur.key_digits);
    probe_done = 1'b0;
    probe_res = '{status: STATUS_FULL, slot_index: '0, found_record: '0};
    if (!occupied) begin
      probe_done = 1'b1;
      if (cur.action == ACTION_INSERT) begin
        probe_res.status = STATUS_INSERTED;
        probe_res.slot_index = SLOT_W'(pos);
      end else begin
        probe_res.status = STATUS_NOT_FOUND;
      end
    end else if (equal) begin
      probe_done = 1'b1;
      if (cur.action == ACTION_INSERT) begin
        probe_res.status = STATUS_DUPLICATE;
      end else begin
        probe_res.status = STATUS_FOUND;
        probe_res.slot_index = SLOT_W'(pos);
        probe_res.found_record = rd_entry.record_word;
      end
    end else if (count == CNT_W'(TABLE_SIZE - 1)) begin
      probe_done = 1'b1;
      probe_res.status = (cur.action == ACTION_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
    end
  end

  assign next_pos = (pos == IDX_W'(TABLE_SIZE - 1)) ? '0 : pos + 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = key_ok ? ST_PROBE : ST_DONE;
        end
      end
      ST_PROBE: begin
        if (probe_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall = (state != ST_IDLE);
    rd_addr = (state == ST_IDLE) ? home : next_pos;
    wr_en = (state == ST_PROBE) && probe_done && (probe_res.status == STATUS_INSERTED);
    out_load = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item registers, probe position and count, pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= '{action: in_data.action, key_length: in_data.key_length,
               key_digits: key_kept, record_word: in_data.record_word};
      pos <= home;
      count <= '0;
      res <= '{status: STATUS_INVALID, slot_index: '0, found_record: '0};
    end else if (state == ST_PROBE) begin
      pos <= next_pos;
      count <= count + 1'b1;
      if (probe_done) begin
        res <= probe_res;
      end
    end
  end

  // Slot memory and its per-slot valid flops.
  assign wr_entry = '{key_length: cur.key_length, key_digits: cur.key_digits,
                      record_word: cur.record_word};

  lpht_slot_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[pos] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  // An insert never overwrites an occupied slot.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !valid[pos])
    else $error("insert wrote an occupied slot");

  // An accepted item always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted item did not start");

  // The probe never walks past the table.
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_PROBE |-> count <= CNT_W'(TABLE_SIZE - 1))
    else $error("probe count overran the table");

  // Only inserted and found results carry a slot or a record.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_FOUND && out_data.status != STATUS_INSERTED
    |-> out_data.slot_index == '0 && out_data.found_record == '0)
    else $error("result fields not zero");
`endif

endmodule

>>> sv/lpht_slot_ram.sv
module lpht_slot_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
